/* sv/cqf_pkg.sv */
// ---------------------------------------------------------------------------
// cqf_pkg
// Shared types, codes and helpers for the circular queue FIFO.
// ---------------------------------------------------------------------------
package cqf_pkg;

    localparam int MAX_SLOTS   = 16;
    localparam int IDX_W       = $clog2(MAX_SLOTS);
    localparam int SLOTS_W     = IDX_W + 1;
    localparam int DATA_W      = 32;
    localparam int REQ_W       = 2;
    localparam int STS_W       = 2;
    localparam int SLOTS_RESET = 5;
    localparam int SLOTS_MIN   = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_ENQ  = 2'd0,
        REQ_DEQ  = 2'd1,
        REQ_SHOW = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [STS_W-1:0] {
        STS_OK         = 2'd0,
        STS_OVERFLOW   = 2'd1,
        STS_UNDERFLOW  = 2'd2,
        STS_EMPTY_SHOW = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    load_out;
        t_status out_status;
        logic    out_from_ram;
        logic    out_last;
        logic    enq;
        logic    walk_start;
        logic    fetch;
        logic    adv_head;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic walk_at_tail;
        logic out_free;
    } t_sts;

    function automatic logic [IDX_W-1:0] f_next(input logic [IDX_W-1:0]   idx,
                                                input logic [SLOTS_W-1:0] slots);
        logic [SLOTS_W-1:0] n;
        n = {1'b0, idx} + SLOTS_W'(1);
        return (n >= slots) ? '0 : n[IDX_W-1:0];
    endfunction

endpackage

/* sv/cqf_ram.sv */
// ---------------------------------------------------------------------------
// cqf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cqf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cqf_datapath.sv */
// ---------------------------------------------------------------------------
// cqf_datapath
// Ring indices, slot RAM, walk pointer, size register and result register.
// ---------------------------------------------------------------------------
module cqf_datapath
    import cqf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SLOTS_W-1:0]  i_cfg_wdata,
    input  logic [DATA_W-1:0]   i_push_value,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STS_W-1:0]    o_out_status,
    output logic [DATA_W-1:0]   o_out_data,
    output logic                o_out_last
);

    logic [SLOTS_W-1:0] r_slots;
    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_tail;
    logic [IDX_W-1:0]   r_walk;
    logic               r_out_valid;
    logic [STS_W-1:0]   r_out_status;
    logic [DATA_W-1:0]  r_out_data;
    logic               r_out_last;

    logic [IDX_W-1:0]   tail_nxt;
    logic [IDX_W-1:0]   walk_nxt;
    logic [SLOTS_W-1:0] cfg_slots;
    logic               do_write;
    logic [DATA_W-1:0]  rdata;

    assign tail_nxt = f_next(r_tail, r_slots);
    assign walk_nxt = f_next(r_walk, r_slots);
    assign do_write = i_cmd.enq && !o_sts.full;

    always_comb begin
        priority if (i_cfg_wdata < SLOTS_W'(SLOTS_MIN)) begin
            cfg_slots = SLOTS_W'(SLOTS_MIN);
        end else if (i_cfg_wdata > SLOTS_W'(MAX_SLOTS)) begin
            cfg_slots = SLOTS_W'(MAX_SLOTS);
        end else begin
            cfg_slots = i_cfg_wdata;
        end
    end

    assign o_sts.empty        = (r_head == r_tail);
    assign o_sts.full         = (tail_nxt == r_head);
    assign o_sts.walk_at_tail = (r_walk == r_tail);
    assign o_sts.out_free     = !r_out_valid || i_out_ready;

    cqf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (tail_nxt),
        .i_wdata (i_push_value),
        .i_re    (i_cmd.fetch),
        .i_raddr (walk_nxt),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots     <= SLOTS_W'(SLOTS_RESET);
            r_head      <= '0;
            r_tail      <= '0;
            r_walk      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_slots <= cfg_slots;
                r_head  <= '0;
                r_tail  <= '0;
            end else begin
                if (do_write) begin
                    r_tail <= tail_nxt;
                end
                if (i_cmd.adv_head) begin
                    r_head <= walk_nxt;
                end
            end
            if (i_cmd.walk_start) begin
                r_walk <= r_head;
            end else if (i_cmd.fetch) begin
                r_walk <= walk_nxt;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.out_status;
            r_out_data   <= i_cmd.out_from_ram ? rdata : '0;
            r_out_last   <= i_cmd.out_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_data   = r_out_data;
    assign o_out_last   = r_out_last;

endmodule

/* sv/cqf_ctrl.sv */
// ---------------------------------------------------------------------------
// cqf_ctrl
// Request sequencer: decodes requests and steps dequeue and show reads.
// ---------------------------------------------------------------------------
module cqf_ctrl
    import cqf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic [REQ_W-1:0] i_req_type,
    output logic             o_req_ready,
    input  t_sts             i_sts,
    output t_cmd             o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_WAIT  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_deq, n_deq;
    logic   fin;

    always_comb begin
        n_state     = r_state;
        n_deq       = r_deq;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        fin         = r_deq || i_sts.walk_at_tail;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = i_sts.out_free;
                if (i_req_valid && i_sts.out_free) begin
                    unique case (t_req'(i_req_type))
                        REQ_ENQ: begin
                            o_cmd.enq        = 1'b1;
                            o_cmd.load_out   = 1'b1;
                            o_cmd.out_last   = 1'b1;
                            o_cmd.out_status = i_sts.full ? STS_OVERFLOW : STS_OK;
                        end
                        REQ_DEQ, REQ_SHOW: begin
                            if (i_sts.empty) begin
                                o_cmd.load_out   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = (t_req'(i_req_type) == REQ_DEQ) ?
                                                   STS_UNDERFLOW : STS_EMPTY_SHOW;
                            end else begin
                                o_cmd.walk_start = 1'b1;
                                n_deq            = (t_req'(i_req_type) == REQ_DEQ);
                                n_state          = ST_FETCH;
                            end
                        end
                        REQ_NONE: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                o_cmd.fetch    = 1'b1;
                o_cmd.adv_head = r_deq;
                n_state        = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out     = 1'b1;
                    o_cmd.out_from_ram = 1'b1;
                    o_cmd.out_status   = STS_OK;
                    o_cmd.out_last     = fin;
                    n_state            = fin ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_deq   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_deq   <= n_deq;
        end
    end

endmodule

/* sv/circular_queue_fifo_unit.sv */
// ---------------------------------------------------------------------------
// circular_queue_fifo_unit
// Ring-buffer FIFO of signed 32-bit words with one slot kept empty.
// ---------------------------------------------------------------------------
// Enqueue, an ignored request code and any request on an empty queue are
// handled in the idle state. A dequeue reads one stored word, a show reads
// every stored entry in turn; each word goes through the registered read port
// of the slot RAM before it reaches the result register. A new request is
// taken while the previous result still waits in the output register, provided
// it is taken in that same cycle. Writing the size register empties the queue.
// ---------------------------------------------------------------------------
module circular_queue_fifo_unit
    import cqf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SLOTS_W-1:0]  i_cfg_wdata,   // ring_slots
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [DATA_W-1:0]   s_axis_tdata,  // [31:0] push_value
    input  logic [REQ_W-1:0]    s_axis_tuser,  // [1:0] req_type
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [DATA_W-1:0]   m_axis_tdata,  // [31:0] data
    output logic [STS_W-1:0]    m_axis_tuser,  // [1:0] status
    output logic                m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    cqf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .i_req_type  (s_axis_tuser),
        .o_req_ready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    cqf_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push_value (s_axis_tdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );

endmodule

/* sv/cqf_checker.sv */
// ---------------------------------------------------------------------------
// cqf_checker
// Port-level checks on the circular queue FIFO, bound to the top level.
// ---------------------------------------------------------------------------
module cqf_checker
    import cqf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tready,
    input  logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  logic [DATA_W-1:0]  m_axis_tdata,
    input  logic [STS_W-1:0]   m_axis_tuser,
    input  logic               m_axis_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STS_OK) |-> (m_axis_tdata == '0))
        else $error("non-ok result carries data");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != STS_OK) |-> m_axis_tlast)
        else $error("non-ok result not last");

    // no new request while a result is stuck
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while output stalled");

endmodule

bind circular_queue_fifo_unit cqf_checker u_cqf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
